// ----- rtl/ctrm_pkg.sv -----
// Package for the crank tooth RPM meter: shared widths, register indexes,
// reset values, command and result structs, and the back-end state type.
// No dependencies.
package ctrm_pkg;

  // Default timestamp width and fixed field widths.
  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int NOW_W         = 32;
  localparam int TEETH_W       = 6;
  localparam int DEBOUNCE_W    = 16;
  localparam int RPM_W         = 14;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TEETH_PER_REV = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_REV       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REV       = 3'd4;

  // Register reset values.
  localparam logic [TEETH_W-1:0]    TEETH_RST    = 6'd11;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd200;
  localparam logic [CFG_W-1:0]      TIMEOUT_RST  = 32'd1000000;
  localparam logic [CFG_W-1:0]      MIN_REV_RST  = 32'd6000;
  localparam logic [CFG_W-1:0]      MAX_REV_RST  = 32'd200000;

  // Speed is 60000000 divided by the revolution time, saturated.
  localparam int                   NUM_BITS      = 26;
  localparam logic [NUM_BITS-1:0]  RPM_NUMERATOR = 26'd60000000;
  localparam logic [RPM_W-1:0]     RPM_LIMIT     = 14'd10000;
  localparam int                   DIV_CNT_W     = $clog2(NUM_BITS);

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 2;

  typedef struct packed {
    logic [TEETH_W-1:0]    teeth_per_rev;
    logic [DEBOUNCE_W-1:0] debounce_us;
    logic [CFG_W-1:0]      timeout_us;
    logic [CFG_W-1:0]      min_rev_us;
    logic [CFG_W-1:0]      max_rev_us;
  } cfg_t;

  // What the back end must do with the speed for one request.
  typedef enum logic [1:0] {
    OP_KEEP  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_REV   = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               rev_done;
    logic               stopped;
    logic [TEETH_W-1:0] teeth;
  } cmd_ctl_t;

  typedef struct packed {
    logic               rev_done;
    logic               stopped;
    logic [TEETH_W-1:0] teeth_seen;
  } res_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DIV  = 1'b1
  } back_state_t;

endpackage

// ----- rtl/ctrm_front.sv -----
// Front end of the crank tooth RPM meter: classifies each accepted request,
// keeps edge time, revolution start and tooth count, and emits a command.
// Depends on ctrm_pkg.
module ctrm_front #(
  parameter int TIME_BITS = ctrm_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctrm_pkg::cfg_t                cfg,
  input  logic                          accept,
  input  logic                          kind,
  input  logic [ctrm_pkg::NOW_W-1:0]    now_us,
  output ctrm_pkg::cmd_ctl_t            cmd_ctl,
  output logic [TIME_BITS-1:0]          cmd_rev_time
);

  localparam int CW = (TIME_BITS > ctrm_pkg::NOW_W) ? TIME_BITS : ctrm_pkg::NOW_W;

  logic [TIME_BITS-1:0]        last_edge_r, last_edge_nxt;
  logic [TIME_BITS-1:0]        rev_start_r, rev_start_nxt;
  logic [ctrm_pkg::TEETH_W-1:0] tooth_r, tooth_nxt;

  logic [CW-1:0]               now_ext;
  logic [TIME_BITS-1:0]        now_t;
  logic [TIME_BITS-1:0]        gap;
  logic                        timed_out;
  logic                        debounced;
  logic [ctrm_pkg::TEETH_W-1:0] tooth_inc;
  logic                        rev_end;

  // Timestamp reduced or extended to the time width, and the edge gap.
  assign now_ext   = CW'(now_us);
  assign now_t     = now_ext[TIME_BITS-1:0];
  assign gap       = now_t - last_edge_r;
  assign timed_out = CW'(gap) > CW'(cfg.timeout_us);
  assign debounced = CW'(gap) >= CW'(cfg.debounce_us);
  assign tooth_inc = tooth_r + ctrm_pkg::TEETH_W'(1);
  assign rev_end   = (tooth_inc >= cfg.teeth_per_rev) || (tooth_inc == '0);

  // Classify the request and work out the next state.
  always_comb begin
    last_edge_nxt    = last_edge_r;
    rev_start_nxt    = rev_start_r;
    tooth_nxt        = tooth_r;
    cmd_ctl.op       = ctrm_pkg::OP_KEEP;
    cmd_ctl.rev_done = 1'b0;
    cmd_ctl.stopped  = 1'b0;
    cmd_rev_time     = '0;
    if (timed_out) begin
      cmd_ctl.op      = ctrm_pkg::OP_CLEAR;
      cmd_ctl.stopped = 1'b1;
      if (!kind) begin
        tooth_nxt     = '0;
        last_edge_nxt = now_t;
        rev_start_nxt = now_t;
      end
    end else if (!kind && debounced) begin
      last_edge_nxt = now_t;
      if (rev_end) begin
        cmd_ctl.op       = ctrm_pkg::OP_REV;
        cmd_ctl.rev_done = 1'b1;
        cmd_rev_time     = now_t - rev_start_r;
        rev_start_nxt    = now_t;
        tooth_nxt        = '0;
      end else begin
        tooth_nxt = tooth_inc;
      end
    end
    cmd_ctl.teeth = tooth_nxt;
  end

  // State registers, updated only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      rev_start_r <= '0;
      tooth_r     <= '0;
    end else if (accept) begin
      last_edge_r <= last_edge_nxt;
      rev_start_r <= rev_start_nxt;
      tooth_r     <= tooth_nxt;
    end
  end

endmodule

// ----- rtl/ctrm_fifo.sv -----
// Small command queue between the front and back ends of the RPM meter.
// Depends on ctrm_pkg for its default depth.
module ctrm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ctrm_pkg::CMD_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/ctrm_div.sv -----
// Restoring divider of the constant speed numerator by the revolution time,
// one quotient bit per cycle.
// Depends on ctrm_pkg.
module ctrm_div #(
  parameter int TIME_BITS = ctrm_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [TIME_BITS-1:0]           divisor,
  output logic                           done,
  output logic [ctrm_pkg::NUM_BITS-1:0]  quotient
);

  logic [TIME_BITS-1:0]            dvsr_r;
  logic [TIME_BITS-1:0]            rem_r, rem_nxt;
  logic [ctrm_pkg::NUM_BITS-1:0]   quo_r, quo_nxt;
  logic [ctrm_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [TIME_BITS:0]              trial;
  logic [TIME_BITS:0]              diff;
  logic                            fits;

  // One restoring step: bring down the next numerator bit and try to subtract.
  assign trial = {rem_r, ctrm_pkg::RPM_NUMERATOR[cnt_r]};
  assign diff  = trial - {1'b0, dvsr_r};
  assign fits  = trial >= {1'b0, dvsr_r};

  always_comb begin
    rem_nxt = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
    quo_nxt = {quo_r[ctrm_pkg::NUM_BITS-2:0], fits};
  end

  // Control: busy while stepping, done held until the next start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (cnt_r == '0)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr_r <= divisor;
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= ctrm_pkg::DIV_CNT_W'(ctrm_pkg::NUM_BITS - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - ctrm_pkg::DIV_CNT_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/ctrm_back.sv -----
// Back end of the RPM meter: takes commands from the queue, keeps the speed,
// runs the divider on a revolution in the sane window and holds the result.
// Depends on ctrm_pkg and ctrm_div.
module ctrm_back #(
  parameter int TIME_BITS = ctrm_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctrm_pkg::cfg_t                cfg,
  input  logic                          cmd_empty,
  input  ctrm_pkg::cmd_ctl_t            cmd_ctl,
  input  logic [TIME_BITS-1:0]          cmd_rev_time,
  output logic                          cmd_pop,
  output logic                          res_valid,
  input  logic                          res_pop,
  output ctrm_pkg::res_t                res,
  output logic [ctrm_pkg::RPM_W-1:0]    speed
);

  localparam int CW = (TIME_BITS > ctrm_pkg::CFG_W) ? TIME_BITS : ctrm_pkg::CFG_W;

  ctrm_pkg::back_state_t           state_r, state_nxt;
  logic [ctrm_pkg::RPM_W-1:0]      speed_r, speed_nxt;
  logic                            res_valid_r, res_valid_nxt;
  ctrm_pkg::res_t                  res_r, res_nxt;
  logic                            slot_free;
  logic                            in_window;
  logic                            div_start;
  logic                            div_done;
  logic [ctrm_pkg::NUM_BITS-1:0]   div_quo;
  logic [ctrm_pkg::RPM_W-1:0]      speed_sat;

  ctrm_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (cmd_rev_time),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign slot_free = !res_valid_r || res_pop;
  assign in_window = (CW'(cmd_rev_time) > CW'(cfg.min_rev_us)) &&
                     (CW'(cmd_rev_time) < CW'(cfg.max_rev_us));
  assign speed_sat = (div_quo > ctrm_pkg::NUM_BITS'(ctrm_pkg::RPM_LIMIT)) ?
                     ctrm_pkg::RPM_LIMIT : div_quo[ctrm_pkg::RPM_W-1:0];

  // Next state and outputs of the command sequencer.
  always_comb begin
    state_nxt     = state_r;
    speed_nxt     = speed_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_pop;
    cmd_pop       = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      ctrm_pkg::BK_IDLE: begin
        if (!cmd_empty && slot_free) begin
          cmd_pop            = 1'b1;
          res_nxt.rev_done   = cmd_ctl.rev_done;
          res_nxt.stopped    = cmd_ctl.stopped;
          res_nxt.teeth_seen = cmd_ctl.teeth;
          case (cmd_ctl.op)
            ctrm_pkg::OP_CLEAR: begin
              speed_nxt     = '0;
              res_valid_nxt = 1'b1;
            end
            ctrm_pkg::OP_REV: begin
              if (in_window) begin
                div_start = 1'b1;
                state_nxt = ctrm_pkg::BK_DIV;
              end else begin
                res_valid_nxt = 1'b1;
              end
            end
            default: begin
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ctrm_pkg::BK_DIV: begin
        if (div_done && slot_free) begin
          speed_nxt     = speed_sat;
          res_valid_nxt = 1'b1;
          state_nxt     = ctrm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = ctrm_pkg::BK_IDLE;
      end
    endcase
  end

  // Sequencer state, speed and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctrm_pkg::BK_IDLE;
      speed_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign speed     = speed_r;

endmodule

// ----- rtl/crank_tooth_rpm_meter.sv -----
// Crank tooth RPM meter.
// Usage: push one request per crank falling edge (in_kind = 0) or per poll
// (in_kind = 1) with its microsecond timestamp while in_full is low. Each
// request gives exactly one result, presented in order on the out_ ports while
// out_empty is low and taken with out_pop.
// The front end classifies a request in the cycle it is accepted and writes a
// command into a two-entry queue. The back end, when idle with a free result
// slot, takes the command off the queue and, for an ordinary request, registers
// its result at the same edge. A request that ends a revolution inside the sane
// window instead runs the one-bit-per-cycle divider over the 26 numerator bits,
// and the back end takes no further command until the divider is done and the
// speed and result are registered. Other requests go at one per cycle through
// the queue and the back end while out_pop keeps up and no division is running.
// A stalled receiver holds the result register; the queue then fills and
// in_full rises, after which no request is taken.
// Reset (rst_n low, synchronous) clears the speed, tooth count and times,
// empties the queue and loads the register defaults. Configuration is written
// through cfg_we, cfg_idx and cfg_wdata while the block is idle.
// Depends on ctrm_pkg, ctrm_front, ctrm_fifo and ctrm_back.
module crank_tooth_rpm_meter #(
  parameter int TIME_BITS = ctrm_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic                             in_kind,
  input  logic [ctrm_pkg::NOW_W-1:0]       in_now_us,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [ctrm_pkg::RPM_W-1:0]       out_rpm,
  output logic                             out_rev_done,
  output logic                             out_stopped,
  output logic [ctrm_pkg::TEETH_W-1:0]     out_teeth_seen,
  input  logic                             cfg_we,
  input  logic [ctrm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ctrm_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int CTL_W = $bits(ctrm_pkg::cmd_ctl_t);
  localparam int ENT_W = CTL_W + TIME_BITS;

  ctrm_pkg::cfg_t       cfg_r;
  logic                 accept;
  ctrm_pkg::cmd_ctl_t   fr_ctl;
  logic [TIME_BITS-1:0] fr_rev_time;
  logic [ENT_W-1:0]     q_wdata;
  logic [ENT_W-1:0]     q_rdata;
  logic                 q_empty;
  logic                 q_pop;
  ctrm_pkg::cmd_ctl_t   bk_ctl;
  logic [TIME_BITS-1:0] bk_rev_time;
  logic                 res_valid;
  ctrm_pkg::res_t       res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.teeth_per_rev <= ctrm_pkg::TEETH_RST;
      cfg_r.debounce_us   <= ctrm_pkg::DEBOUNCE_RST;
      cfg_r.timeout_us    <= ctrm_pkg::TIMEOUT_RST;
      cfg_r.min_rev_us    <= ctrm_pkg::MIN_REV_RST;
      cfg_r.max_rev_us    <= ctrm_pkg::MAX_REV_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ctrm_pkg::REG_TEETH_PER_REV: cfg_r.teeth_per_rev <= cfg_wdata[ctrm_pkg::TEETH_W-1:0];
        ctrm_pkg::REG_DEBOUNCE:      cfg_r.debounce_us   <= cfg_wdata[ctrm_pkg::DEBOUNCE_W-1:0];
        ctrm_pkg::REG_TIMEOUT:       cfg_r.timeout_us    <= cfg_wdata;
        ctrm_pkg::REG_MIN_REV:       cfg_r.min_rev_us    <= cfg_wdata;
        ctrm_pkg::REG_MAX_REV:       cfg_r.max_rev_us    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign accept = in_push && !in_full;

  ctrm_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .accept       (accept),
    .kind         (in_kind),
    .now_us       (in_now_us),
    .cmd_ctl      (fr_ctl),
    .cmd_rev_time (fr_rev_time)
  );

  // Command queue between front and back.
  assign q_wdata = {fr_ctl, fr_rev_time};

  ctrm_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (ctrm_pkg::CMD_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (q_wdata),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign bk_ctl      = ctrm_pkg::cmd_ctl_t'(q_rdata[ENT_W-1:TIME_BITS]);
  assign bk_rev_time = q_rdata[TIME_BITS-1:0];

  ctrm_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd_empty    (q_empty),
    .cmd_ctl      (bk_ctl),
    .cmd_rev_time (bk_rev_time),
    .cmd_pop      (q_pop),
    .res_valid    (res_valid),
    .res_pop      (out_pop),
    .res          (res),
    .speed        (out_rpm)
  );

  assign out_empty      = !res_valid;
  assign out_rev_done   = res.rev_done;
  assign out_stopped    = res.stopped;
  assign out_teeth_seen = res.teeth_seen;

endmodule
